### sv/starfield_projection_engine_unit_defines.svh
// Assertion macros used by the starfield projection engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef STARFIELD_PROJECTION_ENGINE_UNIT_DEFINES_SVH
`define STARFIELD_PROJECTION_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SPE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/spe_pkg.sv
// Types, constants and the divider step for the starfield projection engine.
// No dependencies; imported by the top level and the testbench.
package spe_pkg;

   // field widths
   localparam int FUNC_W     = 2;
   localparam int IDX_W      = 7;
   localparam int RX_W       = 9;
   localparam int RY_W       = 8;
   localparam int RZ_W       = 8;
   localparam int PX_W       = 9;
   localparam int PY_W       = 8;
   localparam int COL_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int WARP_W     = 5;
   localparam int TH_W       = 8;
   localparam int DEPTH_W    = 9;
   localparam int DVD_W      = 16;   // |pos| * 128 fits in 16 bits
   localparam int DVS_W      = 8;    // positive depth is 1..255
   localparam int PROJ_W     = 18;   // signed projected coordinate

   // pipeline shape: stage 1 reads, stage 2 preps, stages 3..6 divide
   localparam int PIPE_LAST      = 6;
   localparam int DIV_FIRST      = 3;
   localparam int STEPS_PER_STG  = 4;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ERASE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WARP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MID  = 2'd2;

   // colours
   localparam logic [COL_W-1:0] COL_ERASE = 2'd0;
   localparam logic [COL_W-1:0] COL_NEAR  = 2'd1;
   localparam logic [COL_W-1:0] COL_MID   = 2'd2;
   localparam logic [COL_W-1:0] COL_FAR   = 2'd3;

   // reset values of the registers
   localparam logic [WARP_W-1:0] WARP_RST = 5'd2;
   localparam logic [TH_W-1:0]   NEAR_RST = 8'd50;
   localparam logic [TH_W-1:0]   MID_RST  = 8'd100;

   // screen geometry
   localparam logic [RX_W-1:0]        CENTRE_X   = 9'd160;
   localparam logic [RY_W-1:0]        CENTRE_Y   = 8'd100;
   localparam logic [DEPTH_W-1:0]     FAR_DEPTH  = 9'd255;
   localparam logic signed [PROJ_W-1:0] CENTRE_X_S = 18'sd160;
   localparam logic signed [PROJ_W-1:0] CENTRE_Y_S = 18'sd100;
   localparam logic signed [PROJ_W-1:0] SCREEN_W_S = 18'sd320;
   localparam logic signed [PROJ_W-1:0] SCREEN_H_S = 18'sd200;
   localparam int PROJ_SHIFT = 7;

   // one star table entry
   typedef struct packed {
      logic [RX_W-1:0]    pos_x;    // signed
      logic [RY_W-1:0]    pos_y;    // signed
      logic [DEPTH_W-1:0] depth_z;  // signed
      logic [PX_W-1:0]    last_px;
      logic [PY_W-1:0]    last_py;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // restoring divider state: dividend shifts out, quotient shifts in
   typedef struct packed {
      logic [DVS_W-1:0] rem;
      logic [DVD_W-1:0] dvd;
   } div_type;

   typedef struct packed {
      logic              valid;
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  idx;
      logic              act;    // index inside the table
      logic [RX_W-1:0]   rand_x;
      logic [RY_W-1:0]   rand_y;
      logic [RZ_W-1:0]   rand_z;
      entry_type         entry;
      logic              zpos;   // depth > 0
      logic              sx;
      logic              sy;
      logic [DVS_W-1:0]  dvsr;
      div_type           div_x;
      div_type           div_y;
   } stage_type;

   function automatic div_type div_step(div_type cur, logic [DVS_W-1:0] d);
      logic [DVS_W:0] trial;
      div_type        nxt;
      trial   = {cur.rem, cur.dvd[DVD_W-1]};
      nxt.dvd = {cur.dvd[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
         nxt.rem    = DVS_W'(trial - {1'b0, d});
         nxt.dvd[0] = 1'b1;
      end else begin
         nxt.rem = trial[DVS_W-1:0];
      end
      return nxt;
   endfunction

   function automatic stage_type div_stage(stage_type s);
      stage_type r;
      r = s;
      for (int i = 0; i < STEPS_PER_STG; i++) begin
         r.div_x = div_step(r.div_x, r.dvsr);
         r.div_y = div_step(r.div_y, r.dvsr);
      end
      return r;
   endfunction

endpackage

### sv/starfield_projection_engine_unit.sv
// Starfield projection engine: star table, pipelined divider and pixel output.
// Depends on spe_pkg, spe_ram and starfield_projection_engine_unit_defines.svh.
//
// Use: each request names a star and a function (init, erase, advance). Erase
// and an on-screen advance return one response (pixel_x, pixel_y, colour);
// init, respawns and ignored requests return nothing. Requests are taken when
// req_valid is high and req_stall low; responses leave when rsp_valid is high
// and rsp_stall low. Registers are written through csr_* (csr_ready is always
// high) while no request is in flight; the user keeps to this, as the block
// leaves it unchecked. A request passes through the six pipeline stages and
// then the output register. Throughput: one request per cycle while req_stall
// is low. A request for a star still in a pipeline stage waits until it has
// left the last stage, which a response stall can delay; the table is read on
// entry and written back from the last stage with no bypass.
// Reset: registers return to warp 2, thresholds 50 and 100; the pipeline
// empties and a clearing pass zeroes the table, one star per cycle, from star
// 0 up to NUM_STARS-1, with req_stall held high.
// Stalls: a stalled response sits in the output register; stages behind it
// keep filling until the pipeline is full, then req_stall rises.
module starfield_projection_engine_unit #(
   parameter int NUM_STARS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   // requests
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [spe_pkg::FUNC_W-1:0]        req_func,
   input  logic [spe_pkg::IDX_W-1:0]         req_star_index,
   input  logic [spe_pkg::RX_W-1:0]          req_rand_x,
   input  logic [spe_pkg::RY_W-1:0]          req_rand_y,
   input  logic [spe_pkg::RZ_W-1:0]          req_rand_z,
   // responses
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [spe_pkg::PX_W-1:0]          rsp_pixel_x,
   output logic [spe_pkg::PY_W-1:0]          rsp_pixel_y,
   output logic [spe_pkg::COL_W-1:0]         rsp_colour,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spe_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import spe_pkg::*;

   `include "starfield_projection_engine_unit_defines.svh"

   localparam int ADDR_W = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

   // ---------------- registers ----------------
   logic [WARP_W-1:0] warp_ff;
   logic [TH_W-1:0]   near_ff;
   logic [TH_W-1:0]   mid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         warp_ff <= WARP_RST;
         near_ff <= NEAR_RST;
         mid_ff  <= MID_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WARP: warp_ff <= csr_wdata[WARP_W-1:0];
            CSR_NEAR: near_ff <= csr_wdata[TH_W-1:0];
            CSR_MID:  mid_ff  <= csr_wdata[TH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- table clearing after reset ----------------
   logic              clear_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clear_ff) begin
         if (clr_cnt_ff == ADDR_W'(NUM_STARS - 1)) begin
            clear_ff <= 1'b0;
         end else begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // ---------------- pipeline control ----------------
   stage_type st_ff [1:PIPE_LAST];
   stage_type st_in [1:PIPE_LAST];
   logic      rdy    [1:PIPE_LAST+1];
   logic      hazard;
   logic      any_valid;
   logic      accept;
   logic      in_range;

   // output register
   logic              out_valid_ff;
   logic [PX_W-1:0]   out_px_ff;
   logic [PY_W-1:0]   out_py_ff;
   logic [COL_W-1:0]  out_col_ff;

   // a stage may load when empty or when its contents move on
   always_comb begin
      rdy[PIPE_LAST+1] = !out_valid_ff || !rsp_stall;
      for (int k = PIPE_LAST; k >= 1; k--) begin
         rdy[k] = !st_ff[k].valid || rdy[k+1];
      end
   end

   // same star still in flight: it has not left the last stage yet
   always_comb begin
      hazard    = 1'b0;
      any_valid = 1'b0;
      for (int k = 1; k <= PIPE_LAST; k++) begin
         if (st_ff[k].valid && (st_ff[k].idx == req_star_index)) begin
            hazard = 1'b1;
         end
         any_valid = any_valid | st_ff[k].valid;
      end
   end

   assign in_range  = 32'(req_star_index) < NUM_STARS;
   assign req_stall = clear_ff || !rdy[1] || hazard;
   assign accept    = req_valid && !req_stall;

   // ---------------- star table ----------------
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // final-stage decisions
   logic      fin_wr;
   logic      fin_res;
   entry_type fin_entry;
   logic [PX_W-1:0]  fin_px;
   logic [PY_W-1:0]  fin_py;
   logic [COL_W-1:0] fin_col;
   logic      fin_leave;

   assign ram_rd_en   = accept && in_range;
   assign ram_rd_addr = ADDR_W'(req_star_index);
   assign fin_leave   = st_ff[PIPE_LAST].valid && rdy[PIPE_LAST+1];
   assign ram_wr_en   = clear_ff || (fin_leave && fin_wr);
   assign ram_wr_addr = clear_ff ? clr_cnt_ff : ADDR_W'(st_ff[PIPE_LAST].idx);
   assign ram_wr_data = clear_ff ? '0 : ENTRY_W'(fin_entry);

   spe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_STARS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------- stage inputs ----------------
   logic [RX_W-1:0] abs_x;
   logic [RY_W-1:0] abs_y;

   always_comb begin
      // stage 1: request captured; table read issued in the same cycle
      st_in[1]        = '0;
      st_in[1].valid  = accept;
      st_in[1].func   = req_func;
      st_in[1].idx    = req_star_index;
      st_in[1].act    = in_range;
      st_in[1].rand_x = req_rand_x;
      st_in[1].rand_y = req_rand_y;
      st_in[1].rand_z = req_rand_z;

      // stage 2: entry arrives; set up magnitudes and divisor
      st_in[2]       = st_ff[1];
      st_in[2].entry = entry_type'(ram_rd_data);
      st_in[2].zpos  = !st_in[2].entry.depth_z[DEPTH_W-1] && (st_in[2].entry.depth_z != '0);
      st_in[2].dvsr  = st_in[2].zpos ? st_in[2].entry.depth_z[DVS_W-1:0] : DVS_W'(1);
      st_in[2].sx    = st_in[2].entry.pos_x[RX_W-1];
      st_in[2].sy    = st_in[2].entry.pos_y[RY_W-1];
      // -256 and -128 become 256 and 128, still unsigned in these widths
      abs_x = st_in[2].sx ? RX_W'(-st_in[2].entry.pos_x) : st_in[2].entry.pos_x;
      abs_y = st_in[2].sy ? RY_W'(-st_in[2].entry.pos_y) : st_in[2].entry.pos_y;
      st_in[2].div_x.rem = '0;
      st_in[2].div_y.rem = '0;
      st_in[2].div_x.dvd = DVD_W'({abs_x, PROJ_SHIFT'(0)});
      st_in[2].div_y.dvd = DVD_W'({abs_y, PROJ_SHIFT'(0)});

      // stages 3..6: four quotient bits per stage
      for (int k = DIV_FIRST; k <= PIPE_LAST; k++) begin
         st_in[k] = div_stage(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= PIPE_LAST; k++) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // ---------------- final stage: project, classify, update ----------------
   logic signed [PROJ_W-1:0] qx_s;
   logic signed [PROJ_W-1:0] qy_s;
   logic signed [PROJ_W-1:0] nx;
   logic signed [PROJ_W-1:0] ny;
   logic                     on_screen;
   logic [COL_W-1:0]         depth_col;
   entry_type                respawn;
   stage_type                fs;

   always_comb begin
      fs   = st_ff[PIPE_LAST];
      qx_s = $signed(PROJ_W'(fs.div_x.dvd));
      qy_s = $signed(PROJ_W'(fs.div_y.dvd));
      nx   = (fs.sx ? -qx_s : qx_s) + CENTRE_X_S;
      ny   = (fs.sy ? -qy_s : qy_s) + CENTRE_Y_S;
      on_screen = (nx > 18'sd0) && (nx < SCREEN_W_S) && (ny > 18'sd0) && (ny < SCREEN_H_S);

      if (fs.entry.depth_z[TH_W-1:0] < near_ff) begin
         depth_col = COL_NEAR;
      end else if (fs.entry.depth_z[TH_W-1:0] < mid_ff) begin
         depth_col = COL_MID;
      end else begin
         depth_col = COL_FAR;
      end

      respawn         = fs.entry;
      respawn.pos_x   = fs.rand_x - CENTRE_X;
      respawn.pos_y   = fs.rand_y - CENTRE_Y;
      respawn.depth_z = FAR_DEPTH;

      fin_wr    = 1'b0;
      fin_res   = 1'b0;
      fin_entry = fs.entry;
      fin_px    = nx[PX_W-1:0];
      fin_py    = ny[PY_W-1:0];
      fin_col   = depth_col;

      case (fs.func)
         FUNC_INIT: begin
            fin_wr            = fs.act;
            fin_entry         = respawn;
            fin_entry.depth_z = DEPTH_W'(fs.rand_z);
         end
         FUNC_ERASE: begin
            fin_res = fs.act;
            fin_px  = fs.entry.last_px;
            fin_py  = fs.entry.last_py;
            fin_col = COL_ERASE;
         end
         FUNC_ADVANCE: begin
            fin_wr = fs.act;
            if (fs.zpos && on_screen) begin
               fin_res           = fs.act;
               fin_entry.last_px = nx[PX_W-1:0];
               fin_entry.last_py = ny[PY_W-1:0];
               fin_entry.depth_z = fs.entry.depth_z - {4'b0000, warp_ff};
            end else begin
               fin_entry = respawn;
            end
         end
         default: ;
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy[PIPE_LAST+1]) begin
         out_valid_ff <= fs.valid && fin_res;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[PIPE_LAST+1]) begin
         out_px_ff  <= fin_px;
         out_py_ff  <= fin_py;
         out_col_ff <= fin_col;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_pixel_x = out_px_ff;
   assign rsp_pixel_y = out_py_ff;
   assign rsp_colour  = out_col_ff;

   // ---------------- assertions ----------------
   `SPE_ASSERT_NOW(a_no_rw_collision, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
      "table read and write hit the same star in one cycle")
   `SPE_ASSERT_NOW(a_clear_idle, clear_ff, !any_valid && !out_valid_ff && !accept,
      "pipeline active during table clearing")
   `SPE_ASSERT_NEXT(a_result_lands, fin_leave && fin_res, rsp_valid,
      "finished result did not reach the output register")
   `SPE_ASSERT_NOW(a_draw_on_screen, rsp_valid && (rsp_colour != COL_ERASE),
      (rsp_pixel_x != 9'd0) && (rsp_pixel_y != 8'd0) && (rsp_pixel_x < 9'd320)
      && (rsp_pixel_y < 8'd200), "drawn pixel outside the screen")

endmodule

### sv/spe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the star table.
module spe_ram #(
   parameter int WIDTH = 43,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### verif/starfield_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the starfield projection engine: keeps its own star table,
// predicts the pixel of each accepted request and compares responses in order.
// Depends on spe_pkg; instantiated by starfield_projection_engine_unit_test.
module starfield_pixel_checker #(
   parameter int NUM_STARS = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [spe_pkg::FUNC_W-1:0]     req_func,
   input  logic [spe_pkg::IDX_W-1:0]      req_star_index,
   input  logic [spe_pkg::RX_W-1:0]       req_rand_x,
   input  logic [spe_pkg::RY_W-1:0]       req_rand_y,
   input  logic [spe_pkg::RZ_W-1:0]       req_rand_z,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [spe_pkg::PX_W-1:0]       rsp_pixel_x,
   input  logic [spe_pkg::PY_W-1:0]       rsp_pixel_y,
   input  logic [spe_pkg::COL_W-1:0]      rsp_colour,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [spe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spe_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             pixel_mismatches,
   output int                             pixels_outstanding
);

   import spe_pkg::*;

   typedef struct packed {
      logic [PX_W-1:0]  px;
      logic [PY_W-1:0]  py;
      logic [COL_W-1:0] colour;
   } pixel_type;

   // shadow star table
   logic signed [RX_W-1:0]    star_x [NUM_STARS];
   logic signed [RY_W-1:0]    star_y [NUM_STARS];
   logic signed [DEPTH_W-1:0] star_z [NUM_STARS];
   logic [PX_W-1:0]           drawn_x [NUM_STARS];
   logic [PY_W-1:0]           drawn_y [NUM_STARS];

   logic [WARP_W-1:0] warp;
   logic [TH_W-1:0]   near_th;
   logic [TH_W-1:0]   mid_th;

   pixel_type expected_pixels[$];
   int        mismatch_tally;

   // new position relative to screen center; subtraction wraps to field width
   function automatic void respawn(int i, logic [RX_W-1:0] rx, logic [RY_W-1:0] ry);
      star_x[i] = rx - CENTRE_X;
      star_y[i] = ry - CENTRE_Y;
   endfunction

   // applies one request to the table; returns 1 when it draws a pixel
   function automatic bit step_star(input logic [FUNC_W-1:0] func,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [RX_W-1:0] rx,
                                    input logic [RY_W-1:0] ry,
                                    input logic [RZ_W-1:0] rz,
                                    output pixel_type pix);
      int z;
      int nx;
      int ny;
      bit drawn;
      drawn = 1'b0;
      pix   = '0;
      if (int'(idx) >= NUM_STARS) return 1'b0;
      case (func)
         FUNC_INIT: begin
            respawn(int'(idx), rx, ry);
            star_z[idx] = {1'b0, rz};
         end
         FUNC_ERASE: begin
            pix.px     = drawn_x[idx];
            pix.py     = drawn_y[idx];
            pix.colour = COL_ERASE;
            drawn      = 1'b1;
         end
         FUNC_ADVANCE: begin
            z = int'(star_z[idx]);
            if (z > 0) begin
               // int division truncates toward zero
               nx = (int'(star_x[idx]) * (1 << PROJ_SHIFT)) / z + int'(CENTRE_X);
               ny = (int'(star_y[idx]) * (1 << PROJ_SHIFT)) / z + int'(CENTRE_Y);
               drawn = nx > 0 && nx < SCREEN_W_S && ny > 0 && ny < SCREEN_H_S;
            end
            if (drawn) begin
               pix.px     = nx[PX_W-1:0];
               pix.py     = ny[PY_W-1:0];
               pix.colour = z < int'(near_th) ? COL_NEAR :
                            z < int'(mid_th)  ? COL_MID  : COL_FAR;
               drawn_x[idx] = pix.px;
               drawn_y[idx] = pix.py;
               star_z[idx]  = DEPTH_W'(z - int'(warp));
            end else begin
               respawn(int'(idx), rx, ry);
               star_z[idx] = FAR_DEPTH;
            end
         end
         default: ;
      endcase
      return drawn;
   endfunction

   always @(posedge clock) begin
      pixel_type seen;
      pixel_type want;
      pixel_type predicted;
      if (reset) begin
         warp    = WARP_RST;
         near_th = NEAR_RST;
         mid_th  = MID_RST;
         for (int i = 0; i < NUM_STARS; i++) begin
            star_x[i]  = '0;
            star_y[i]  = '0;
            star_z[i]  = '0;
            drawn_x[i] = '0;
            drawn_y[i] = '0;
         end
         expected_pixels.delete();
         mismatch_tally = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WARP: warp    = csr_wdata[WARP_W-1:0];
               CSR_NEAR: near_th = csr_wdata[TH_W-1:0];
               CSR_MID:  mid_th  = csr_wdata[TH_W-1:0];
               default: ;
            endcase
         end
         // responses first: one leaving now always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            seen.px     = rsp_pixel_x;
            seen.py     = rsp_pixel_y;
            seen.colour = rsp_colour;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel x=%0d y=%0d colour=%0d",
                        $time, seen.px, seen.py, seen.colour);
               mismatch_tally++;
            end else begin
               want = expected_pixels.pop_front();
               if (seen !== want) begin
                  $display("%0t: pixel mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           $time, want.px, want.py, want.colour,
                           seen.px, seen.py, seen.colour);
                  mismatch_tally++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (step_star(req_func, req_star_index, req_rand_x, req_rand_y, req_rand_z,
                          predicted))
               expected_pixels.push_back(predicted);
         end
      end
      pixel_mismatches   <= mismatch_tally;
      pixels_outstanding <= expected_pixels.size();
   end

endmodule

### verif/starfield_projection_engine_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the starfield projection engine: drives requests, register
// writes and response stalls; starfield_pixel_checker does the predicting.
// Depends on spe_pkg, starfield_pixel_checker and starfield_projection_engine_unit.
module starfield_projection_engine_unit_test;
   import spe_pkg::*;

   localparam int NUM_STARS     = 128;
   localparam int PHASE_ITEMS   = 330;     // counted requests per register setting
   localparam int SETTLE_CYCLES = 12;      // twice the pipeline depth
   localparam int DRAIN_LIMIT   = 50000;

   // codes with no name in the package
   localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [IDX_W-1:0]      req_star_index = '0;
   logic [RX_W-1:0]       req_rand_x = '0;
   logic [RY_W-1:0]       req_rand_y = '0;
   logic [RZ_W-1:0]       req_rand_z = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PX_W-1:0]       rsp_pixel_x;
   logic [PY_W-1:0]       rsp_pixel_y;
   logic [COL_W-1:0]      rsp_colour;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int pixel_mismatches;
   int pixels_outstanding;

   // percent chance of an idle gap on the request side / a stall on the response side
   int idle_pct   = 25;
   int stall_pct  = 25;
   int stall_left = 0;

   starfield_projection_engine_unit #(.NUM_STARS(NUM_STARS)) dut (.*);

   starfield_pixel_checker #(.NUM_STARS(NUM_STARS)) pixel_check (.*);

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length(int pct, int longest);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(longest, 8);
      return $urandom_range(3, 1);
   endfunction

   // response back-pressure: a stall burst holds rsp_stall for its whole length
   always @(posedge clock) begin
      int burst;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         burst = gap_length(stall_pct, 40);
         rsp_stall  <= burst > 0;
         stall_left <= burst > 0 ? burst - 1 : 0;
      end
   end

   // One request: hold it until taken, then maybe drop valid for a gap.
   // With no gap valid stays high straight into the next request.
   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [IDX_W-1:0] idx,
                               input logic [RX_W-1:0] rx,
                               input logic [RY_W-1:0] ry,
                               input logic [RZ_W-1:0] rz);
      int gap;
      req_valid      <= 1'b1;
      req_func       <= func;
      req_star_index <= idx;
      req_rand_x     <= rx;
      req_rand_y     <= ry;
      req_rand_z     <= rz;
      do @(posedge clock); while (req_stall);
      gap = gap_length(idle_pct, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // warp data is 8 bits on the bus, block keeps the low 5
   task automatic program_regs(input logic [CSR_DATA_W-1:0] warp_data,
                               input logic [CSR_DATA_W-1:0] near_data,
                               input logic [CSR_DATA_W-1:0] mid_data);
      write_csr(CSR_WARP, warp_data);
      write_csr(CSR_NEAR, near_data);
      write_csr(CSR_MID, mid_data);
      csr_valid <= 1'b0;
   endtask

   // Wait for every predicted pixel, then let requests that draw nothing
   // (init, respawns, ignored codes) fall out of the pipeline.
   task automatic drain();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pixels_outstanding != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic. Most requests hit a small set of stars so each one lives
   // through spawn, many advances, erases and respawns; the rest spread over
   // the whole table. Ignored function codes are noise and are not counted.
   task automatic random_burst(input int count);
      int                 taken;
      int                 pick;
      logic [FUNC_W-1:0]  func;
      logic [IDX_W-1:0]   idx;
      logic [RX_W-1:0]    rx;
      logic [RY_W-1:0]    ry;
      logic [RZ_W-1:0]    rz;
      taken = 0;
      while (taken < count) begin
         pick = $urandom_range(99);
         func = pick < 8  ? FUNC_INIT :
                pick < 22 ? FUNC_ERASE :
                pick < 25 ? FUNC_UNUSED : FUNC_ADVANCE;
         idx = ($urandom_range(3) != 0) ? IDX_W'($urandom_range(15, 0))
                                        : IDX_W'($urandom_range(127, 0));
         // on-screen randoms mostly, sometimes the full field range
         rx = ($urandom_range(9) != 0) ? RX_W'($urandom_range(319, 0))
                                       : RX_W'($urandom_range(511, 0));
         ry = ($urandom_range(9) != 0) ? RY_W'($urandom_range(199, 0))
                                       : RY_W'($urandom_range(255, 0));
         rz = ($urandom_range(9) != 0) ? RZ_W'($urandom_range(254, 0))
                                       : RZ_W'($urandom_range(255, 0));
         send_request(func, idx, rx, ry, rz);
         if (func != FUNC_UNUSED) taken++;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset register values (warp 2, thresholds 50 / 100).
      // The clearing pass after reset holds req_stall; send_request waits it out.
      send_request(FUNC_ERASE, 0, 0, 0, 0);           // erase of a never drawn star
      send_request(FUNC_UNUSED, 1, 511, 255, 255);    // unused code, all ones
      send_request(FUNC_ADVANCE, 2, 0, 0, 0);         // zero depth: respawn at corner
      send_request(FUNC_ADVANCE, 2, 0, 0, 0);         // far colour from the respawn
      send_request(FUNC_INIT, 3, 0, 0, 128);          // projects onto column 0
      send_request(FUNC_ADVANCE, 3, 319, 199, 0);     // off screen: respawn
      send_request(FUNC_ADVANCE, 3, 0, 0, 0);         // draws from the new spot
      send_request(FUNC_INIT, 4, 319, 199, 128);      // lands on the last column and row
      send_request(FUNC_ADVANCE, 4, 0, 0, 0);
      send_request(FUNC_ERASE, 4, 0, 0, 0);
      send_request(FUNC_INIT, 5, 160, 200, 128);      // row 200 is off screen
      send_request(FUNC_ADVANCE, 5, 0, 0, 0);
      send_request(FUNC_INIT, 6, 511, 255, 255);      // randoms past the screen wrap
      send_request(FUNC_ADVANCE, 6, 0, 0, 0);
      send_request(FUNC_INIT, 7, 100, 50, 0);         // init at depth 0
      send_request(FUNC_ADVANCE, 7, 20, 30, 0);
      send_request(FUNC_INIT, 8, 160, 100, 1);        // near colour, then depth below 0
      send_request(FUNC_ADVANCE, 8, 0, 0, 0);
      send_request(FUNC_ADVANCE, 8, 5, 6, 0);         // negative depth: respawn
      send_request(FUNC_INIT, 9, 160, 100, 50);       // exactly the near threshold
      send_request(FUNC_ADVANCE, 9, 0, 0, 0);
      send_request(FUNC_ADVANCE, 9, 0, 0, 0);         // 48 is below it
      send_request(FUNC_INIT, 10, 160, 100, 100);     // exactly the mid threshold
      send_request(FUNC_ADVANCE, 10, 0, 0, 0);
      send_request(FUNC_ADVANCE, 10, 0, 0, 0);
      send_request(FUNC_ERASE, 127, 0, 0, 0);         // last table entry

      // random phases, each under its own register setting and idle pattern
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: begin
               idle_pct  = 30;
               stall_pct = 30;
            end
            1: begin
               write_csr(CSR_UNUSED, 8'hA5);          // no such register
               program_regs(8'd1, 8'd0, 8'd0);        // slowest legal warp, all far
               idle_pct  = 0;
               stall_pct = 0;
            end
            2: begin
               program_regs(8'd16, 8'd255, 8'd255);   // fastest legal warp, near below 255
               idle_pct  = 50;
               stall_pct = 50;
            end
            3: begin
               program_regs(8'hFF, 8'd200, 8'd80);    // warp 31, near above mid
               idle_pct  = 20;
               stall_pct = 70;
            end
            4: begin
               program_regs(8'h20, 8'd30, 8'd120);    // warp 0: depth never drops
               idle_pct  = 40;
               stall_pct = 10;
            end
            default: begin
               program_regs(CSR_DATA_W'($urandom_range(16, 1)),
                            CSR_DATA_W'($urandom_range(255, 0)),
                            CSR_DATA_W'($urandom_range(255, 0)));
               idle_pct  = $urandom_range(60, 0);
               stall_pct = $urandom_range(60, 0);
            end
         endcase
         random_burst(PHASE_ITEMS);
      end

      drain();
      if (pixel_mismatches == 0 && pixels_outstanding == 0)
         $display("** starfield_projection_engine_unit: PASSED **");
      else
         $display("** starfield_projection_engine_unit: FAILED **");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #15_000_000;
      $display("** starfield_projection_engine_unit: FAILED **");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/spe_pkg.sv
sv/spe_ram.sv
sv/starfield_projection_engine_unit.sv
verif/starfield_pixel_checker.sv
verif/starfield_projection_engine_unit_test.sv
